// File: rtl/rau_pkg.sv
package rau_pkg;

    // Default word size used for the range check on results.
    localparam int WORD_BITS_DEF = 32;

    // Packed stream widths, rounded up to whole bytes.
    localparam int IN_BITS  = 136;
    localparam int OUT_BITS = 72;

    // Operation codes carried in req_type.
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_INC = 3'd4;
    localparam logic [2:0] OP_DEC = 3'd5;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_RED,
        S_GCD,
        S_DIV_M,
        S_DIV_D,
        S_RED_DONE,
        S_CMP_X,
        S_CMP_Y,
        S_CMP_FLAG,
        S_DISPATCH,
        S_ADD_L,
        S_ADD_TA,
        S_ADD_TB,
        S_ADD_COMB,
        S_MUL_N,
        S_MUL_D,
        S_FIN
    } state_t;

    // Which value the reduction routine is working on.
    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_L,
        PH_R
    } phase_t;

endpackage

// File: rtl/rational_arith_unit_top.sv
// Channel   Direction  Fields (tdata, lowest bit first)
// s_axis    in         req_type[2:0] a_num[34:3] a_den[66:35] b_num[98:67] b_den[130:99]
// m_axis    out        res_num[31:0] res_den[62:32] a_less[63] a_equal[64] a_greater[65]
//                      zero_den_error[66] overflow[67]
//
// A transaction with a zero denominator goes from the check straight to the result.
// The rest take a time set by the binary gcd loop (one subtract or shift per cycle) and
// the restoring divider (one quotient bit per cycle); up to four reductions run per item.
// Reset clears the sequencer and empties the output register.
// A finished result waits in the output register; the next transaction may be taken
// meanwhile, and it stalls in its last state until the register is free.
module rational_arith_unit_top #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // req_type, a_num, a_den, b_num, b_den, zero fill
    input  logic [rau_pkg::IN_BITS-1:0]  s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // res_num, res_den, a_less, a_equal, a_greater, zero_den_error, overflow, zero fill
    output logic [rau_pkg::OUT_BITS-1:0] m_axis_tdata
);
    import rau_pkg::*;

    localparam logic [63:0] LIMIT = (64'd1 << (WORD_BITS - 1)) - 64'd1;

    state_t state_reg, state_next;
    phase_t phase_reg;
    logic [2:0]  op_reg;
    logic        a_neg_reg, b_neg_reg, rneg_reg;
    logic [31:0] a_mag_reg, a_den_reg, b_mag_reg, b_den_reg;
    logic [31:0] qa_reg, qb_reg;
    logic [63:0] rm_reg, rd_reg;
    logic [63:0] gx_reg, gy_reg, g_reg;
    logic [5:0]  k_reg;
    logic [63:0] div_q_reg, div_r_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] x_reg, y_reg, l_reg;
    logic        lt_reg, eq_reg, gt_reg, err_reg;
    logic        out_valid_reg;
    logic [OUT_BITS-1:0] out_data_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] product;
    logic [64:0] rem_sh;
    logic        div_ge;
    logic [63:0] rem_new, quo_new;
    logic        out_load;
    logic [31:0] in_a_num, in_a_den, in_b_num, in_b_den;
    logic        badd_neg;
    logic [31:0] badd_mag, badd_den;
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic        ovf;

    // Field split of the incoming transaction.
    assign in_a_num = s_axis_tdata[34:3];
    assign in_a_den = s_axis_tdata[66:35];
    assign in_b_num = s_axis_tdata[98:67];
    assign in_b_den = s_axis_tdata[130:99];

    // Shared multiplier: operands chosen by the sequencer step.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_CMP_X:
            begin
                mul_a = a_mag_reg;
                mul_b = b_den_reg;
            end
            S_CMP_Y:
            begin
                mul_a = b_mag_reg;
                mul_b = a_den_reg;
            end
            S_ADD_L:
            begin
                mul_a = qa_reg;
                mul_b = b_den_reg;
            end
            S_ADD_TA:
            begin
                mul_a = a_mag_reg;
                mul_b = qb_reg;
            end
            S_ADD_TB:
            begin
                mul_a = b_mag_reg;
                mul_b = qa_reg;
            end
            S_MUL_N:
            begin
                mul_a = a_mag_reg;
                mul_b = (op_reg == OP_DIV) ? b_den_reg : b_mag_reg;
            end
            S_MUL_D:
            begin
                mul_a = a_den_reg;
                mul_b = (op_reg == OP_DIV) ? b_mag_reg : b_den_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = {32'd0, mul_a} * {32'd0, mul_b};

    // Restoring divider step: one quotient bit per cycle.
    assign rem_sh  = {div_r_reg, div_q_reg[63]};
    assign div_ge  = rem_sh >= {1'b0, g_reg};
    assign rem_new = div_ge ? 64'(rem_sh - {1'b0, g_reg}) : rem_sh[63:0];
    assign quo_new = {div_q_reg[62:0], div_ge};

    // Second operand of a sum: b, negated b, or plus or minus one.
    always_comb
    begin
        badd_neg = b_neg_reg;
        badd_mag = b_mag_reg;
        badd_den = b_den_reg;
        case (op_reg)
            OP_SUB:
            begin
                badd_neg = (b_mag_reg != 32'd0) && !b_neg_reg;
            end
            OP_INC:
            begin
                badd_neg = 1'b0;
                badd_mag = 32'd1;
                badd_den = 32'd1;
            end
            OP_DEC:
            begin
                badd_neg = 1'b1;
                badd_mag = 32'd1;
                badd_den = 32'd1;
            end
            default:
            begin
                badd_neg = b_neg_reg;
            end
        endcase
    end

    // Final range check and sign restore.
    assign ovf     = !err_reg && ((rm_reg > LIMIT) || (rd_reg > LIMIT));
    assign res_num = (err_reg || ovf) ? 32'd0
                   : (rneg_reg ? 32'(-rm_reg[31:0]) : rm_reg[31:0]);
    assign res_den = (err_reg || ovf) ? 31'd0 : rd_reg[30:0];

    assign out_load = (state_reg == S_FIN) && (!out_valid_reg || m_axis_tready);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if ((a_den_reg == 32'd0) || (b_den_reg == 32'd0))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_RED;
                end
            end
            S_RED:
            begin
                state_next = (rm_reg == 64'd0) ? S_RED_DONE : S_GCD;
            end
            S_GCD:
            begin
                if (gx_reg == gy_reg)
                begin
                    state_next = S_DIV_M;
                end
            end
            S_DIV_M:
            begin
                if (cnt_reg == 6'd0)
                begin
                    state_next = S_DIV_D;
                end
            end
            S_DIV_D:
            begin
                if (cnt_reg == 6'd0)
                begin
                    state_next = S_RED_DONE;
                end
            end
            S_RED_DONE:
            begin
                case (phase_reg)
                    PH_A:    state_next = S_RED;
                    PH_B:    state_next = S_CMP_X;
                    PH_L:    state_next = S_ADD_L;
                    default: state_next = S_FIN;
                endcase
            end
            S_CMP_X:    state_next = S_CMP_Y;
            S_CMP_Y:    state_next = S_CMP_FLAG;
            S_CMP_FLAG: state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                case (op_reg)
                    OP_ADD, OP_SUB, OP_INC, OP_DEC: state_next = S_RED;
                    OP_MUL: state_next = S_MUL_N;
                    OP_DIV: state_next = (b_mag_reg == 32'd0) ? S_FIN : S_MUL_N;
                    default: state_next = S_FIN;
                endcase
            end
            S_ADD_L:    state_next = S_ADD_TA;
            S_ADD_TA:   state_next = S_ADD_TB;
            S_ADD_TB:   state_next = S_ADD_COMB;
            S_ADD_COMB: state_next = S_RED;
            S_MUL_N:    state_next = S_MUL_D;
            S_MUL_D:    state_next = S_RED;
            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);

    // Datapath registers, stepped by the sequencer.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                op_reg    <= s_axis_tdata[2:0];
                a_mag_reg <= in_a_num[31] ? 32'(-in_a_num) : in_a_num;
                a_den_reg <= in_a_den[31] ? 32'(-in_a_den) : in_a_den;
                a_neg_reg <= in_a_num[31] ^ in_a_den[31];
                b_mag_reg <= in_b_num[31] ? 32'(-in_b_num) : in_b_num;
                b_den_reg <= in_b_den[31] ? 32'(-in_b_den) : in_b_den;
                b_neg_reg <= in_b_num[31] ^ in_b_den[31];
                lt_reg    <= 1'b0;
                eq_reg    <= 1'b0;
                gt_reg    <= 1'b0;
                err_reg   <= 1'b0;
            end
            S_CHECK:
            begin
                err_reg   <= (a_den_reg == 32'd0) || (b_den_reg == 32'd0);
                phase_reg <= PH_A;
                rm_reg    <= {32'd0, a_mag_reg};
                rd_reg    <= {32'd0, a_den_reg};
                rneg_reg  <= a_neg_reg;
            end
            S_RED:
            begin
                if (rm_reg == 64'd0)
                begin
                    rneg_reg <= 1'b0;
                    rd_reg   <= 64'd1;
                end
                gx_reg <= rm_reg;
                gy_reg <= rd_reg;
                k_reg  <= '0;
            end
            S_GCD:
            begin
                // Binary gcd: one shift or subtract per cycle.
                if (gx_reg == gy_reg)
                begin
                    g_reg     <= gx_reg << k_reg;
                    div_q_reg <= rm_reg;
                    div_r_reg <= '0;
                    cnt_reg   <= 6'd63;
                end
                else if (!gx_reg[0] && !gy_reg[0])
                begin
                    gx_reg <= gx_reg >> 1;
                    gy_reg <= gy_reg >> 1;
                    k_reg  <= k_reg + 6'd1;
                end
                else if (!gx_reg[0])
                begin
                    gx_reg <= gx_reg >> 1;
                end
                else if (!gy_reg[0])
                begin
                    gy_reg <= gy_reg >> 1;
                end
                else if (gx_reg > gy_reg)
                begin
                    gx_reg <= gx_reg - gy_reg;
                end
                else
                begin
                    gy_reg <= gy_reg - gx_reg;
                end
            end
            S_DIV_M:
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    rm_reg    <= quo_new;
                    div_q_reg <= rd_reg;
                    div_r_reg <= '0;
                    cnt_reg   <= 6'd63;
                end
                else
                begin
                    div_q_reg <= quo_new;
                    div_r_reg <= rem_new;
                end
            end
            S_DIV_D:
            begin
                cnt_reg   <= cnt_reg - 6'd1;
                div_q_reg <= quo_new;
                div_r_reg <= rem_new;
                if (cnt_reg == 6'd0)
                begin
                    rd_reg <= quo_new;
                end
            end
            S_RED_DONE:
            begin
                case (phase_reg)
                    PH_A:
                    begin
                        a_mag_reg <= rm_reg[31:0];
                        a_den_reg <= rd_reg[31:0];
                        a_neg_reg <= rneg_reg;
                        rm_reg    <= {32'd0, b_mag_reg};
                        rd_reg    <= {32'd0, b_den_reg};
                        rneg_reg  <= b_neg_reg;
                        phase_reg <= PH_B;
                    end
                    PH_B:
                    begin
                        b_mag_reg <= rm_reg[31:0];
                        b_den_reg <= rd_reg[31:0];
                        b_neg_reg <= rneg_reg;
                    end
                    PH_L:
                    begin
                        qa_reg <= rm_reg[31:0];
                        qb_reg <= rd_reg[31:0];
                    end
                    default:
                    begin
                        phase_reg <= PH_R;
                    end
                endcase
            end
            S_CMP_X: x_reg <= product;
            S_CMP_Y: y_reg <= product;
            S_CMP_FLAG:
            begin
                // Exact compare by cross products.
                if (a_neg_reg != b_neg_reg)
                begin
                    lt_reg <= a_neg_reg;
                    gt_reg <= !a_neg_reg;
                end
                else if (x_reg == y_reg)
                begin
                    eq_reg <= 1'b1;
                end
                else if ((x_reg < y_reg) != a_neg_reg)
                begin
                    lt_reg <= 1'b1;
                end
                else
                begin
                    gt_reg <= 1'b1;
                end
            end
            S_DISPATCH:
            begin
                case (op_reg)
                    OP_ADD, OP_SUB, OP_INC, OP_DEC:
                    begin
                        // Reduce the two denominators by their gcd first.
                        b_neg_reg <= badd_neg;
                        b_mag_reg <= badd_mag;
                        b_den_reg <= badd_den;
                        rm_reg    <= {32'd0, a_den_reg};
                        rd_reg    <= {32'd0, badd_den};
                        phase_reg <= PH_L;
                    end
                    OP_MUL:
                    begin
                        rneg_reg <= a_neg_reg ^ b_neg_reg;
                    end
                    OP_DIV:
                    begin
                        rneg_reg <= a_neg_reg ^ b_neg_reg;
                        if (b_mag_reg == 32'd0)
                        begin
                            err_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                        rm_reg   <= {32'd0, a_mag_reg};
                        rd_reg   <= {32'd0, a_den_reg};
                        rneg_reg <= a_neg_reg;
                    end
                endcase
            end
            S_ADD_L:  l_reg <= product;
            S_ADD_TA: x_reg <= product;
            S_ADD_TB: y_reg <= product;
            S_ADD_COMB:
            begin
                rd_reg    <= l_reg;
                phase_reg <= PH_R;
                if (a_neg_reg == b_neg_reg)
                begin
                    rm_reg   <= x_reg + y_reg;
                    rneg_reg <= a_neg_reg;
                end
                else if (x_reg >= y_reg)
                begin
                    rm_reg   <= x_reg - y_reg;
                    rneg_reg <= a_neg_reg;
                end
                else
                begin
                    rm_reg   <= y_reg - x_reg;
                    rneg_reg <= b_neg_reg;
                end
            end
            S_MUL_N: rm_reg <= product;
            S_MUL_D:
            begin
                rd_reg    <= product;
                phase_reg <= PH_R;
            end
            default:
            begin
                phase_reg <= phase_reg;
            end
        endcase
    end

    // Output register: holds a result until the downstream side takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {4'd0, ovf, err_reg, gt_reg, eq_reg, lt_reg, res_den, res_num};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// File: rtl/rau_checker.sv
module rau_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [rau_pkg::OUT_BITS-1:0] m_axis_tdata
);
    import rau_pkg::*;

    // A waiting result stays offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn before it was taken");

    // The unit works on one transaction at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    // At most one compare flag is set.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $countones(m_axis_tdata[65:63]) <= 1)
        else $error("more than one compare flag set");

    // An error result carries zero numerator and denominator and no overflow.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[66] |-> m_axis_tdata[62:0] == 63'd0 && !m_axis_tdata[67])
        else $error("error result with nonzero fields");

    // A good result has a nonzero denominator.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[66] && !m_axis_tdata[67] |-> m_axis_tdata[62:32] != 31'd0)
        else $error("valid result with zero denominator");

endmodule

bind rational_arith_unit_top rau_checker u_rau_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

    import rau_pkg::*;

    // Operation codes beyond the package set behave as a plain reduction of a.
    localparam logic [2:0] OP_PASS_A = 3'd6;
    localparam logic [2:0] OP_PASS_B = 3'd7;
    localparam int         LIMIT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] MOST_NEG = 32'h8000_0000;

    // One result as it appears on the master side.
    typedef struct packed {
        logic        overflow;
        logic        zero_den_error;
        logic        a_greater;
        logic        a_equal;
        logic        a_less;
        logic [30:0] res_den;
        logic [31:0] res_num;
    } ratio_result_t;

    // One row of the directed stimulus; expected only typed in where obvious.
    typedef struct {
        logic [2:0]    op;
        logic [31:0]   an;
        logic [31:0]   ad;
        logic [31:0]   bn;
        logic [31:0]   bd;
        bit            typed;
        ratio_result_t want;
    } stim_row_t;

    // Fraction held as sign and magnitude.
    typedef struct {
        bit          neg;
        logic [63:0] mag;
        logic [63:0] den;
    } ratio_t;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_BITS-1:0]  s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_BITS-1:0] m_axis_tdata;

    ratio_result_t pending_results[$];
    int            fail_count;
    bit            stim_done;
    stim_row_t     rows[$];

    rational_arith_unit_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Euclid on 64-bit magnitudes.
    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Lowest terms, zero as 0/1.
    function automatic ratio_t reduce_ratio(ratio_t f);
        logic [63:0] g;
        if (f.mag == 0)
        begin
            f.neg = 1'b0;
            f.den = 1;
            return f;
        end
        g = gcd64(f.mag, f.den);
        f.mag = f.mag / g;
        f.den = f.den / g;
        return f;
    endfunction

    // Magnitude of a 32-bit two's complement word, widened to 64 bits.
    function automatic logic [63:0] word_mag(logic [31:0] v);
        return v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
    endfunction

    function automatic ratio_t sum_ratio(ratio_t a, ratio_t b);
        ratio_t      r;
        logic [63:0] l;
        logic [63:0] ta;
        logic [63:0] tb;
        l = (a.den / gcd64(a.den, b.den)) * b.den;
        ta = a.mag * (l / a.den);
        tb = b.mag * (l / b.den);
        if (a.neg == b.neg)
        begin
            r.mag = ta + tb;
            r.neg = a.neg;
        end
        else if (ta >= tb)
        begin
            r.mag = ta - tb;
            r.neg = a.neg;
        end
        else
        begin
            r.mag = tb - ta;
            r.neg = b.neg;
        end
        r.den = l;
        return reduce_ratio(r);
    endfunction

    function automatic ratio_t product_ratio(ratio_t a, ratio_t b);
        ratio_t r;
        r.neg = a.neg != b.neg;
        r.mag = a.mag * b.mag;
        r.den = a.den * b.den;
        return reduce_ratio(r);
    endfunction

    // Computes the exact result and compare flags for one request.
    function automatic ratio_result_t rational_result(logic [2:0] op, logic [31:0] an,
                                                      logic [31:0] ad, logic [31:0] bn,
                                                      logic [31:0] bd);
        ratio_result_t res;
        ratio_t        a;
        ratio_t        b;
        ratio_t        r;
        ratio_t        one;
        ratio_t        inv;
        logic [63:0]   x;
        logic [63:0]   y;
        bit            ok;
        res = '0;
        a.mag = word_mag(an);
        a.den = word_mag(ad);
        a.neg = an[31] != ad[31];
        b.mag = word_mag(bn);
        b.den = word_mag(bd);
        b.neg = bn[31] != bd[31];
        if (a.den == 0 || b.den == 0)
        begin
            res.zero_den_error = 1'b1;
            return res;
        end
        a = reduce_ratio(a);
        b = reduce_ratio(b);
        x = a.mag * b.den;
        y = b.mag * a.den;
        if (a.neg != b.neg)
        begin
            res.a_less = a.neg;
            res.a_greater = !a.neg;
        end
        else if (x == y)
            res.a_equal = 1'b1;
        else if ((x < y) != a.neg)
            res.a_less = 1'b1;
        else
            res.a_greater = 1'b1;
        one.neg = 1'b0;
        one.mag = 1;
        one.den = 1;
        ok = 1'b1;
        r = a;
        case (op)
            OP_ADD: r = sum_ratio(a, b);
            OP_SUB:
            begin
                b.neg = (b.mag != 0) && !b.neg;
                r = sum_ratio(a, b);
            end
            OP_MUL: r = product_ratio(a, b);
            OP_DIV:
            begin
                if (b.mag == 0)
                begin
                    ok = 1'b0;
                    res.zero_den_error = 1'b1;
                end
                else
                begin
                    inv.neg = b.neg;
                    inv.mag = b.den;
                    inv.den = b.mag;
                    r = product_ratio(a, inv);
                end
            end
            OP_INC: r = sum_ratio(a, one);
            OP_DEC:
            begin
                one.neg = 1'b1;
                r = sum_ratio(a, one);
            end
            default: r = a;
        endcase
        if (ok)
        begin
            if (r.mag > LIMIT_POS || r.den > LIMIT_POS)
                res.overflow = 1'b1;
            else
            begin
                res.res_num = r.neg ? (32'd0 - r.mag[31:0]) : r.mag[31:0];
                res.res_den = r.den[30:0];
            end
        end
        return res;
    endfunction

    // Operand drawn mostly small so that reductions and carries are exercised.
    function automatic logic [31:0] draw_operand();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 4) == 0 ? MOST_NEG : 32'h7FFF_FFFF;
            2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 65535))
                                          : -32'($urandom_range(0, 65535));
            default: return $urandom_range(0, 1) ? 32'($urandom_range(0, 40))
                                                : -32'($urandom_range(0, 40));
        endcase
    endfunction

    function automatic void add_row(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                                    logic [31:0] bn, logic [31:0] bd, bit typed,
                                    ratio_result_t want);
        stim_row_t row;
        row.op = op;
        row.an = an;
        row.ad = ad;
        row.bn = bn;
        row.bd = bd;
        row.typed = typed;
        row.want = want;
        rows.push_back(row);
    endfunction

    // Sender: directed table then random requests.
    initial
    begin
        ratio_result_t err_res;
        ratio_result_t ovf_res;
        ratio_result_t div0_res;
        ratio_result_t one_res;
        ratio_result_t want;
        logic [2:0]    op;
        logic [31:0]   an;
        logic [31:0]   ad;
        logic [31:0]   bn;
        logic [31:0]   bd;
        int            gap;
        fail_count = 0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;

        err_res = '0;
        err_res.zero_den_error = 1'b1;
        div0_res = '0;
        div0_res.zero_den_error = 1'b1;
        div0_res.a_greater = 1'b1;
        ovf_res = '0;
        ovf_res.overflow = 1'b1;
        ovf_res.a_equal = 1'b1;
        one_res = '0;
        one_res.res_num = 32'd1;
        one_res.res_den = 31'd1;
        one_res.a_equal = 1'b1;

        // Zero denominators, for add, subtract, increment and decrement.
        add_row(OP_ADD, 1, 0, 1, 1, 1'b1, err_res);
        add_row(OP_SUB, 1, 1, 1, 0, 1'b1, err_res);
        add_row(OP_INC, 5, 0, 3, 2, 1'b1, err_res);
        add_row(OP_DEC, 0, 0, 0, 0, 1'b1, err_res);
        // Divide by zero keeps the compare flags.
        add_row(OP_DIV, 1, 1, 0, 5, 1'b1, div0_res);
        // Overflow: 0x7FFFFFFF/1 squared, doubled.
        add_row(OP_ADD, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1, 1'b1, ovf_res);
        add_row(OP_MUL, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1, 1'b1, ovf_res);
        // Simple products and unused codes.
        add_row(OP_MUL, 2, 2, 3, 3, 1'b1, one_res);
        add_row(OP_PASS_A, 7, 7, -1, -1, 1'b1, one_res);
        add_row(OP_PASS_B, -4, -4, 2, 2, 1'b1, one_res);
        // Remaining rows checked against the predictor.
        add_row(OP_ADD, 1, 3, 1, 6, 1'b0, '0);
        add_row(OP_SUB, 1, 3, 1, 3, 1'b0, '0);
        add_row(OP_DIV, -3, 4, 5, -7, 1'b0, '0);
        add_row(OP_INC, -1, 1, 0, 1, 1'b0, '0);
        add_row(OP_DEC, 1, -2, 9, 4, 1'b0, '0);
        add_row(OP_ADD, MOST_NEG, 1, 1, 1, 1'b0, '0);
        add_row(OP_SUB, MOST_NEG, MOST_NEG, 32'h7FFF_FFFF, MOST_NEG, 1'b0, '0);
        add_row(OP_MUL, MOST_NEG, 2, 1, MOST_NEG, 1'b0, '0);
        add_row(OP_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFE, MOST_NEG, 32'h7FFF_FFFF, 1'b0, '0);
        add_row(OP_DEC, MOST_NEG, 1, 0, -1, 1'b0, '0);
        add_row(OP_INC, 32'h7FFF_FFFF, 1, -5, 3, 1'b0, '0);
        add_row(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                1'b0, '0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int n = 0; n < rows.size() + 1000; n++)
        begin
            if (n < rows.size())
            begin
                op = rows[n].op;
                an = rows[n].an;
                ad = rows[n].ad;
                bn = rows[n].bn;
                bd = rows[n].bd;
            end
            else
            begin
                op = $urandom_range(0, 7);
                an = draw_operand();
                ad = draw_operand();
                bn = draw_operand();
                bd = draw_operand();
                // Keep zero denominators occasional.
                if (ad == 0 && $urandom_range(0, 3) != 0)
                    ad = 1;
                if (bd == 0 && $urandom_range(0, 3) != 0)
                    bd = 1;
            end
            want = rational_result(op, an, ad, bn, bd);
            if (n < rows.size() && rows[n].typed && want != rows[n].want)
            begin
                $display("%0t: table row %0d disagrees with predictor: expected %h actual %h",
                         $time, n, rows[n].want, want);
                fail_count++;
            end
            // Idle cycles before the next transaction; valid stays high when there are none.
            gap = $urandom_range(0, 9);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= {5'd0, bd, bn, ad, an, op};
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            pending_results.push_back(n < rows.size() && rows[n].typed ? rows[n].want
                                                                      : want);
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stalls, compares each transaction with the oldest expectation.
    initial
    begin
        ratio_result_t got;
        ratio_result_t exp_res;
        int            stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            // Ready stays high when no stall is drawn.
            stall = $urandom_range(0, 9);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            got = m_axis_tdata[67:0];
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                fail_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (got.res_num !== exp_res.res_num)
                    $display("%0t: res_num expected %h actual %h", $time,
                             exp_res.res_num, got.res_num);
                if (got.res_den !== exp_res.res_den)
                    $display("%0t: res_den expected %h actual %h", $time,
                             exp_res.res_den, got.res_den);
                if (got.a_less !== exp_res.a_less)
                    $display("%0t: a_less expected %b actual %b", $time,
                             exp_res.a_less, got.a_less);
                if (got.a_equal !== exp_res.a_equal)
                    $display("%0t: a_equal expected %b actual %b", $time,
                             exp_res.a_equal, got.a_equal);
                if (got.a_greater !== exp_res.a_greater)
                    $display("%0t: a_greater expected %b actual %b", $time,
                             exp_res.a_greater, got.a_greater);
                if (got.zero_den_error !== exp_res.zero_den_error)
                    $display("%0t: zero_den_error expected %b actual %b", $time,
                             exp_res.zero_den_error, got.zero_den_error);
                if (got.overflow !== exp_res.overflow)
                    $display("%0t: overflow expected %b actual %b", $time,
                             exp_res.overflow, got.overflow);
                if (got !== exp_res)
                    fail_count++;
            end
        end
    end

    // End of run: drain, then allow for a late stray result.
    initial
    begin
        wait (stim_done);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2000) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: 1022 items at the longest path through the unit plus stalls, with a wide margin.
    initial
    begin
        #100_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
